/* rtl/ovt_pkg.sv */
// Package for the vendor prefix table: widths, opcodes, status codes and the
// command/status structs between controller and datapath. No dependencies.
package ovt_pkg;
   localparam int unsigned TableEntries = 16384;
   localparam int unsigned AddrW  = $clog2(TableEntries);
   localparam int unsigned CountW = AddrW + 1;
   localparam int unsigned PrefixW = 24;
   localparam int unsigned PosW   = 14;
   localparam int unsigned RandW  = 32;

   typedef enum logic [1:0] {
      OP_CLEAR  = 2'd0,
      OP_INSERT = 2'd1,
      OP_LOOKUP = 2'd2,
      OP_PICK   = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_FULL      = 2'd2,
      ST_EMPTY     = 2'd3
   } status_type;

   localparam logic [1:0] CLASS_WIRELESS = 2'd0;
   localparam logic [1:0] CLASS_OTHER    = 2'd1;

   typedef struct packed {
      logic load;        // capture request
      logic clear;
      logic search_init;
      logic search_step; // issue read at mid
      logic search_upd;  // compare read data
      logic pos_read;    // read at lo
      logic merge_wr;    // write merged mark at lo
      logic shift_init;
      logic shift_rd;    // read idx-1
      logic shift_wr;    // write idx
      logic ins_wr;      // write new entry at lo
      logic mod_init;
      logic mod_step;
      logic scan_init;
      logic scan_rd;
      logic scan_chk;
      logic set_result;  // latch result from entry at lo
      logic set_empty;
      logic set_full;
      logic set_miss;
      logic set_ok_zero;
   } cmd_type;

   typedef struct packed {
      opcode_type op;
      logic search_done;
      logic hit;        // entry at lo matches
      logic full;
      logic already_w;  // hit entry already wireless or no wireless given
      logic shift_done;
      logic mod_done;
      logic class_empty;
      logic class_any;
      logic scan_hit;
      logic scan_end;
   } stat_type;
endpackage

/* rtl/ovt_if.sv */
// Valid/ready channel interfaces for the vendor prefix table.
// Depends on ovt_pkg.
interface ovt_req_if;
   logic                         valid;
   logic                         ready;
   logic [1:0]                   opcode;
   logic [ovt_pkg::PrefixW-1:0]  prefix;
   logic                         is_wireless;
   logic [1:0]                   pick_class;
   logic [ovt_pkg::RandW-1:0]    random_word;
   modport source (output valid, opcode, prefix, is_wireless, pick_class, random_word,
                   input ready);
   modport sink (input valid, opcode, prefix, is_wireless, pick_class, random_word,
                 output ready);
endinterface

interface ovt_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [1:0]                   status;
   logic [ovt_pkg::PosW-1:0]     position;
   logic [ovt_pkg::PrefixW-1:0]  found_prefix;
   logic                         found_wireless;
   modport source (output valid, status, position, found_prefix, found_wireless,
                   input ready);
   modport sink (input valid, status, position, found_prefix, found_wireless,
                 output ready);
endinterface

/* rtl/oui_vendor_table.sv */
// Sorted vendor prefix table, one request at a time.
// Clear empties the table. Lookup runs a binary search over the entries; insert
// searches too, then shifts the entries above the slot up and writes the new one.
// Pick takes the random word modulo the class size bit by bit, then reads the
// entry (any) or scans for it (wireless/other). The next request is accepted only
// after the response is handed off. Synchronous reset empties the table at once.
module oui_vendor_table (
   input logic clock,
   input logic reset,
   ovt_req_if.sink   req,
   ovt_rsp_if.source rsp
);
   import ovt_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   ovt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_fire  (req.valid & req.ready),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   ovt_datapath u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_opcode      (req.opcode),
      .req_prefix      (req.prefix),
      .req_is_wireless (req.is_wireless),
      .req_pick_class  (req.pick_class),
      .req_random_word (req.random_word),
      .res_status      (rsp.status),
      .res_position    (rsp.position),
      .res_prefix      (rsp.found_prefix),
      .res_wireless    (rsp.found_wireless)
   );
endmodule

/* rtl/ovt_datapath.sv */
// Datapath: entry memory, counts, binary search, shifter, serial modulo, scan.
// Depends on ovt_pkg.
module ovt_datapath (
   input  logic                        clock,
   input  logic                        reset,
   input  ovt_pkg::cmd_type            cmd,
   output ovt_pkg::stat_type           stat,
   input  logic [1:0]                  req_opcode,
   input  logic [ovt_pkg::PrefixW-1:0] req_prefix,
   input  logic                        req_is_wireless,
   input  logic [1:0]                  req_pick_class,
   input  logic [ovt_pkg::RandW-1:0]   req_random_word,
   output logic [1:0]                  res_status,
   output logic [ovt_pkg::PosW-1:0]    res_position,
   output logic [ovt_pkg::PrefixW-1:0] res_prefix,
   output logic                        res_wireless
);
   import ovt_pkg::*;

   logic [PrefixW:0] mem [TableEntries];
   logic [PrefixW:0] rd_ff;
   logic [AddrW-1:0] rd_addr;
   logic             wr_en;
   logic [AddrW-1:0] wr_addr;
   logic [PrefixW:0] wr_data;

   logic [1:0]         op_ff, cls_ff;
   logic [PrefixW-1:0] pfx_ff;
   logic               wl_ff;
   logic [RandW-1:0]   rnd_ff;
   logic [CountW-1:0]  cnt_ff, cnt_in, wcnt_ff, wcnt_in;
   logic [CountW-1:0]  lo_ff, lo_in, hi_ff, hi_in, idx_ff, idx_in;
   logic [CountW-1:0]  seen_ff, seen_in, n_ff, n_in;
   logic [CountW-1:0]  rem_ff, rem_in;
   logic [5:0]         bit_ff, bit_in;
   logic [CountW-1:0]  mid;
   logic [CountW:0]    trial;
   logic [1:0]         st_ff, st_in;
   logic [PosW-1:0]    pos_ff, pos_in;
   logic [PrefixW-1:0] rp_ff, rp_in;
   logic               rw_ff, rw_in;
   logic               member;
   logic [CountW-1:0]  idx_m1;

   assign mid    = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign idx_m1 = idx_ff - 1'b1;
   assign trial  = {rem_ff, rnd_ff[bit_ff[4:0]]};
   assign member = (cls_ff == CLASS_WIRELESS) ? rd_ff[0] : !rd_ff[0];

   always_comb begin
      rd_addr = lo_ff[AddrW-1:0];
      if (cmd.search_step) begin
         rd_addr = mid[AddrW-1:0];
      end else if (cmd.shift_rd) begin
         rd_addr = idx_m1[AddrW-1:0];
      end else if (cmd.scan_rd) begin
         rd_addr = idx_ff[AddrW-1:0];
      end else if (cmd.pos_read) begin
         rd_addr = lo_ff[AddrW-1:0];
      end
      wr_en   = cmd.merge_wr | cmd.shift_wr | cmd.ins_wr;
      wr_addr = cmd.shift_wr ? idx_ff[AddrW-1:0] : lo_ff[AddrW-1:0];
      wr_data = cmd.shift_wr ? rd_ff :
                cmd.merge_wr ? {rd_ff[PrefixW:1], 1'b1} : {pfx_ff, wl_ff};
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff  <= req_opcode;
         pfx_ff <= req_prefix;
         wl_ff  <= req_is_wireless;
         cls_ff <= req_pick_class;
         rnd_ff <= req_random_word;
      end
   end

   always_comb begin
      cnt_in = cnt_ff;
      wcnt_in = wcnt_ff;
      if (cmd.clear) begin
         cnt_in = '0;
         wcnt_in = '0;
      end
      if (cmd.merge_wr) begin
         wcnt_in = wcnt_ff + 1'b1;
      end
      if (cmd.ins_wr) begin
         cnt_in = cnt_ff + 1'b1;
         if (wl_ff) begin
            wcnt_in = wcnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         wcnt_ff <= '0;
      end else begin
         cnt_ff  <= cnt_in;
         wcnt_ff <= wcnt_in;
      end
   end

   always_comb begin
      lo_in = lo_ff;
      hi_in = hi_ff;
      idx_in = idx_ff;
      seen_in = seen_ff;
      n_in = n_ff;
      rem_in = rem_ff;
      bit_in = bit_ff;
      if (cmd.search_init) begin
         lo_in = '0;
         hi_in = cnt_ff;
      end
      if (cmd.search_upd) begin
         if (rd_ff[PrefixW:1] < pfx_ff) begin
            lo_in = mid + 1'b1;
         end else begin
            hi_in = mid;
         end
      end
      if (cmd.shift_init) begin
         idx_in = cnt_ff;
      end
      if (cmd.shift_wr) begin
         idx_in = idx_m1;
      end
      if (cmd.mod_init) begin
         n_in = (cls_ff == CLASS_WIRELESS) ? wcnt_ff :
                (cls_ff == CLASS_OTHER) ? cnt_ff - wcnt_ff : cnt_ff;
         rem_in = '0;
         bit_in = 6'(RandW - 1);
      end
      if (cmd.mod_step) begin
         if (trial >= {1'b0, n_ff}) begin
            rem_in = CountW'(trial - {1'b0, n_ff});
         end else begin
            rem_in = trial[CountW-1:0];
         end
         bit_in = bit_ff - 1'b1;
         lo_in = rem_in;
      end
      if (cmd.scan_init) begin
         idx_in = '0;
         seen_in = '0;
      end
      if (cmd.scan_chk) begin
         if (member) begin
            seen_in = seen_ff + 1'b1;
         end
         if (!(member && seen_ff == rem_ff)) begin
            idx_in = idx_ff + 1'b1;
         end else begin
            lo_in = idx_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      lo_ff <= lo_in;
      hi_ff <= hi_in;
      idx_ff <= idx_in;
      seen_ff <= seen_in;
      n_ff <= n_in;
      rem_ff <= rem_in;
      bit_ff <= bit_in;
   end

   always_comb begin
      st_in = st_ff;
      pos_in = pos_ff;
      rp_in = rp_ff;
      rw_in = rw_ff;
      if (cmd.set_result) begin
         st_in = ST_OK;
         pos_in = lo_ff[PosW-1:0];
         rp_in = rd_ff[PrefixW:1];
         rw_in = rd_ff[0] | (cmd.merge_wr);
      end
      if (cmd.ins_wr) begin
         st_in = ST_OK;
         pos_in = lo_ff[PosW-1:0];
         rp_in = pfx_ff;
         rw_in = wl_ff;
      end
      if (cmd.set_empty | cmd.set_full | cmd.set_miss | cmd.set_ok_zero) begin
         st_in = cmd.set_empty ? ST_EMPTY : cmd.set_full ? ST_FULL :
                 cmd.set_miss ? ST_NOT_FOUND : ST_OK;
         pos_in = '0;
         rp_in = '0;
         rw_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      st_ff <= st_in;
      pos_ff <= pos_in;
      rp_ff <= rp_in;
      rw_ff <= rw_in;
   end

   assign res_status   = st_ff;
   assign res_position = pos_ff;
   assign res_prefix   = rp_ff;
   assign res_wireless = rw_ff;

   always_comb begin
      stat.op          = opcode_type'(op_ff);
      stat.search_done = !(lo_ff < hi_ff);
      stat.hit         = (lo_ff < cnt_ff) && (rd_ff[PrefixW:1] == pfx_ff);
      stat.full        = cnt_ff >= CountW'(TableEntries);
      stat.already_w   = rd_ff[0] | !wl_ff;
      stat.shift_done  = !(idx_ff > lo_ff);
      stat.mod_done    = bit_ff == '0;
      stat.class_empty = n_ff == '0;
      stat.class_any   = cls_ff[1];
      stat.scan_hit    = member && seen_ff == rem_ff;
      stat.scan_end    = idx_ff >= cnt_ff;
   end
endmodule

/* rtl/ovt_ctrl.sv */
// Controller state machine sequencing each request through the datapath.
// Depends on ovt_pkg.
module ovt_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_fire,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ovt_pkg::cmd_type  cmd,
   input  ovt_pkg::stat_type stat
);
   import ovt_pkg::*;

   typedef enum logic [13:0] {
      S_IDLE   = 14'b00000000000001,
      S_DISP   = 14'b00000000000010,
      S_SRCH   = 14'b00000000000100,
      S_SWAIT  = 14'b00000000001000,
      S_POSRD  = 14'b00000000010000,
      S_POSCHK = 14'b00000000100000,
      S_SHRD   = 14'b00000001000000,
      S_SHWR   = 14'b00000010000000,
      S_MOD    = 14'b00000100000000,
      S_MODCHK = 14'b00001000000000,
      S_SCRD   = 14'b00010000000000,
      S_SCCHK  = 14'b00100000000000,
      S_PICKRD = 14'b01000000000000,
      S_RESP   = 14'b10000000000000
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = state_ff == S_IDLE;
   assign rsp_valid = state_ff == S_RESP;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               cmd.load = 1'b1;
               state_in = S_DISP;
            end
         end
         S_DISP: begin
            case (stat.op)
               OP_CLEAR: begin
                  cmd.clear = 1'b1;
                  cmd.set_ok_zero = 1'b1;
                  state_in = S_RESP;
               end
               OP_PICK: begin
                  cmd.mod_init = 1'b1;
                  state_in = S_MODCHK;
               end
               default: begin
                  cmd.search_init = 1'b1;
                  state_in = S_SRCH;
               end
            endcase
         end
         S_SRCH: begin
            if (stat.search_done) begin
               cmd.pos_read = 1'b1;
               state_in = S_POSCHK;
            end else begin
               cmd.search_step = 1'b1;
               state_in = S_SWAIT;
            end
         end
         S_SWAIT: begin
            cmd.search_upd = 1'b1;
            state_in = S_SRCH;
         end
         S_POSCHK: begin
            if (stat.hit) begin
               cmd.set_result = 1'b1;
               if (stat.op == OP_INSERT && !stat.already_w) begin
                  cmd.merge_wr = 1'b1;
               end
               state_in = S_RESP;
            end else if (stat.op == OP_LOOKUP) begin
               cmd.set_miss = 1'b1;
               state_in = S_RESP;
            end else if (stat.full) begin
               cmd.set_full = 1'b1;
               state_in = S_RESP;
            end else begin
               cmd.shift_init = 1'b1;
               state_in = S_SHRD;
            end
         end
         S_SHRD: begin
            if (stat.shift_done) begin
               cmd.ins_wr = 1'b1;
               state_in = S_RESP;
            end else begin
               cmd.shift_rd = 1'b1;
               state_in = S_SHWR;
            end
         end
         S_SHWR: begin
            cmd.shift_wr = 1'b1;
            state_in = S_SHRD;
         end
         S_MODCHK: begin
            if (stat.class_empty) begin
               cmd.set_empty = 1'b1;
               state_in = S_RESP;
            end else begin
               state_in = S_MOD;
            end
         end
         S_MOD: begin
            cmd.mod_step = 1'b1;
            if (stat.mod_done) begin
               if (stat.class_any) begin
                  state_in = S_PICKRD;
               end else begin
                  cmd.scan_init = 1'b1;
                  state_in = S_SCRD;
               end
            end
         end
         S_PICKRD: begin
            cmd.pos_read = 1'b1;
            state_in = S_POSRD;
         end
         S_POSRD: begin
            cmd.set_result = 1'b1;
            state_in = S_RESP;
         end
         S_SCRD: begin
            if (stat.scan_end) begin
               cmd.set_empty = 1'b1;
               state_in = S_RESP;
            end else begin
               cmd.scan_rd = 1'b1;
               state_in = S_SCCHK;
            end
         end
         S_SCCHK: begin
            cmd.scan_chk = 1'b1;
            state_in = stat.scan_hit ? S_PICKRD : S_SCRD;
         end
         S_RESP: begin
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule

/* sim/ovt_checker.sv */
`timescale 1ns / 1ps
// Checker for the vendor prefix table: watches request and response channels,
// keeps its own sorted table and compares responses. Depends on ovt_pkg, ovt_if.
module ovt_checker (
   input  logic       clock,
   input  logic       reset,
   ovt_req_if.sink    req_mon,
   ovt_rsp_if.sink    rsp_mon,
   output int         fail_count,
   output int         pending_count
);
   import ovt_pkg::*;

   typedef struct packed {
      status_type          status;
      logic [PosW-1:0]     position;
      logic [PrefixW-1:0]  prefix;
      logic                wireless;
   } answer_type;

   logic [PrefixW-1:0] table_prefix [TableEntries];
   logic               table_mark [TableEntries];
   int unsigned        table_size;
   int unsigned        marked_size;
   answer_type         answer_queue [$];

   function automatic int unsigned first_not_below(logic [PrefixW-1:0] p);
      int unsigned lo, hi, mid;
      lo = 0;
      hi = table_size;
      while (lo < hi) begin
         mid = lo + (hi - lo) / 2;
         if (table_prefix[mid] < p) lo = mid + 1;
         else hi = mid;
      end
      return lo;
   endfunction

   function automatic answer_type predict_table(logic [1:0] op, logic [PrefixW-1:0] p,
                                               logic wl, logic [1:0] cls,
                                               logic [RandW-1:0] rnd);
      answer_type a;
      int unsigned pos, n, k, seen;
      a = '{ST_OK, '0, '0, 1'b0};
      case (opcode_type'(op))
         OP_CLEAR: begin
            table_size = 0;
            marked_size = 0;
         end
         OP_INSERT: begin
            pos = first_not_below(p);
            if (pos < table_size && table_prefix[pos] == p) begin
               if (wl && !table_mark[pos]) begin
                  table_mark[pos] = 1'b1;
                  marked_size++;
               end
               a = '{ST_OK, pos[PosW-1:0], p, table_mark[pos]};
            end else if (table_size >= TableEntries) begin
               a.status = ST_FULL;
            end else begin
               for (int unsigned i = table_size; i > pos; i--) begin
                  table_prefix[i] = table_prefix[i-1];
                  table_mark[i] = table_mark[i-1];
               end
               table_prefix[pos] = p;
               table_mark[pos] = wl;
               table_size++;
               if (wl) marked_size++;
               a = '{ST_OK, pos[PosW-1:0], p, wl};
            end
         end
         OP_LOOKUP: begin
            pos = first_not_below(p);
            if (pos < table_size && table_prefix[pos] == p)
               a = '{ST_OK, pos[PosW-1:0], p, table_mark[pos]};
            else
               a.status = ST_NOT_FOUND;
         end
         default: begin
            if (cls == CLASS_WIRELESS) n = marked_size;
            else if (cls == CLASS_OTHER) n = table_size - marked_size;
            else n = table_size;
            if (n == 0) begin
               a.status = ST_EMPTY;
            end else begin
               k = rnd % n;
               if (cls != CLASS_WIRELESS && cls != CLASS_OTHER) begin
                  a = '{ST_OK, k[PosW-1:0], table_prefix[k], table_mark[k]};
               end else begin
                  seen = 0;
                  for (int unsigned i = 0; i < table_size; i++) begin
                     if (table_mark[i] == (cls == CLASS_WIRELESS)) begin
                        if (seen == k) begin
                           a = '{ST_OK, i[PosW-1:0], table_prefix[i], table_mark[i]};
                           break;
                        end
                        seen++;
                     end
                  end
               end
            end
         end
      endcase
      return a;
   endfunction

   assign pending_count = answer_queue.size();

   always @(posedge clock) begin
      answer_type want;
      if (reset) begin
         table_size = 0;
         marked_size = 0;
         answer_queue.delete();
         fail_count <= 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (answer_queue.size() == 0) begin
               $error("unexpected response status=%0d", rsp_mon.status);
               fail_count <= fail_count + 1;
            end else begin
               want = answer_queue.pop_front();
               if (rsp_mon.status !== want.status ||
                   rsp_mon.position !== want.position ||
                   rsp_mon.found_prefix !== want.prefix ||
                   rsp_mon.found_wireless !== want.wireless)
                  fail_count <= fail_count + 1;
               if (rsp_mon.status !== want.status)
                  $error("status: expected %0d, got %0d", want.status, rsp_mon.status);
               if (rsp_mon.position !== want.position)
                  $error("position: expected %0d, got %0d", want.position,
                         rsp_mon.position);
               if (rsp_mon.found_prefix !== want.prefix)
                  $error("found_prefix: expected %h, got %h", want.prefix,
                         rsp_mon.found_prefix);
               if (rsp_mon.found_wireless !== want.wireless)
                  $error("found_wireless: expected %0d, got %0d", want.wireless,
                         rsp_mon.found_wireless);
            end
         end
         if (req_mon.valid && req_mon.ready)
            answer_queue.push_back(predict_table(req_mon.opcode, req_mon.prefix,
                                                 req_mon.is_wireless, req_mon.pick_class,
                                                 req_mon.random_word));
      end
   end
endmodule

/* sim/tb_oui_vendor_table.sv */
`timescale 1ns / 1ps
// Top of the vendor prefix table testbench: clock, reset, request stimulus,
// response back-pressure and verdict. Depends on ovt_pkg, ovt_if, ovt_checker, oui_vendor_table.
module tb_oui_vendor_table;
   import ovt_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   fail_count, pending_count;
   int   cycle_count = 0;
   int   req_idle_pct = 24, rsp_idle_pct = 51;
   int   sent_count = 0;
   logic [PrefixW-1:0] used_prefix [$];

   ovt_req_if req_ch ();
   ovt_rsp_if rsp_ch ();

   oui_vendor_table dut (.clock(clock), .reset(reset), .req(req_ch.sink),
                         .rsp(rsp_ch.source));
   ovt_checker checker_i (.clock(clock), .reset(reset), .req_mon(req_ch.sink),
                          .rsp_mon(rsp_ch.sink), .fail_count(fail_count),
                          .pending_count(pending_count));

   always #2 clock = ~clock;

   initial begin
      req_ch.valid = 1'b0;
      req_ch.opcode = OP_CLEAR;
      req_ch.prefix = '0;
      req_ch.is_wireless = 1'b0;
      req_ch.pick_class = '0;
      req_ch.random_word = '0;
      rsp_ch.ready = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 3_000_000) begin
         $display("tb_oui_vendor_table: FAIL");
         $finish;
      end
   end

   always @(negedge clock)
      rsp_ch.ready <= !reset && ($urandom_range(99) >= rsp_idle_pct);

   task automatic send_request(opcode_type op, logic [PrefixW-1:0] p, logic wl,
                               logic [1:0] cls, logic [RandW-1:0] rnd);
      int idle;
      idle = 0;
      while ($urandom_range(99) < req_idle_pct) idle++;
      if (idle > 0) begin
         req_ch.valid <= 1'b0;
         repeat (idle) @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.opcode <= op;
      req_ch.prefix <= p;
      req_ch.is_wireless <= wl;
      req_ch.pick_class <= cls;
      req_ch.random_word <= rnd;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      @(negedge clock);
      sent_count++;
      if (op == OP_INSERT) used_prefix.push_back(p);
   endtask

   task automatic random_request();
      int sel;
      logic [PrefixW-1:0] p;
      sel = $urandom_range(99);
      if (used_prefix.size() > 0 && $urandom_range(1))
         p = used_prefix[$urandom_range(used_prefix.size() - 1)];
      else
         p = PrefixW'($urandom);
      if (sel < 2)
         send_request(OP_CLEAR, p, 1'b0, '0, '0);
      else if (sel < 45)
         send_request(OP_INSERT, p, 1'($urandom_range(1)), 2'($urandom), $urandom);
      else if (sel < 70)
         send_request(OP_LOOKUP, p, 1'($urandom_range(1)), 2'($urandom), $urandom);
      else
         send_request(OP_PICK, PrefixW'($urandom), 1'($urandom_range(1)),
                      2'($urandom_range(3)), $urandom);
   endtask

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      send_request(OP_PICK, '0, 1'b0, 2'd2, '1);
      send_request(OP_PICK, '0, 1'b0, 2'd0, '0);
      send_request(OP_LOOKUP, '0, 1'b0, 2'd0, '0);
      send_request(OP_INSERT, 24'hFFFFFF, 1'b0, 2'd3, '1);
      send_request(OP_INSERT, 24'h000000, 1'b1, 2'd0, '0);
      send_request(OP_INSERT, 24'h800000, 1'b0, 2'd0, '0);
      send_request(OP_INSERT, 24'h800000, 1'b1, 2'd0, '0);
      send_request(OP_INSERT, 24'h800000, 1'b0, 2'd0, '0);
      send_request(OP_INSERT, 24'h555555, 1'b0, 2'd0, '0);
      send_request(OP_LOOKUP, 24'hFFFFFF, 1'b0, 2'd0, '0);
      send_request(OP_LOOKUP, 24'h000000, 1'b0, 2'd0, '0);
      send_request(OP_LOOKUP, 24'hAAAAAA, 1'b1, 2'd1, '1);
      send_request(OP_PICK, '1, 1'b1, 2'd0, 32'hFFFFFFFF);
      send_request(OP_PICK, '0, 1'b0, 2'd1, 32'h80000001);
      send_request(OP_PICK, '0, 1'b0, 2'd2, 32'h00000003);
      send_request(OP_PICK, '0, 1'b0, 2'd3, 32'h7FFFFFFF);
      send_request(OP_CLEAR, '1, 1'b1, 2'd3, '1);
      send_request(OP_LOOKUP, 24'h800000, 1'b0, 2'd0, '0);
      send_request(OP_PICK, '0, 1'b0, 2'd1, '0);
      repeat (600) random_request();
      req_idle_pct = 51;
      rsp_idle_pct = 24;
      repeat (600) random_request();
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      repeat (600) random_request();
      req_ch.valid <= 1'b0;
      while (pending_count != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      $display("Covered %0d requests: clear, insert with duplicates, lookup hit/miss,",
               sent_count);
      $display("and picks over wireless, other and any classes, incl. empty classes.");
      if (fail_count == 0)
         $display("tb_oui_vendor_table: PASS");
      else
         $display("tb_oui_vendor_table: FAIL");
      $finish;
   end
endmodule
